// ----- rtl/chunk_stream_crc_checker_defines.svh -----
// assertion macros for the chunk stream crc checker
`ifndef CHUNK_STREAM_CRC_CHECKER_DEFINES_SVH
`define CHUNK_STREAM_CRC_CHECKER_DEFINES_SVH

// same-cycle implication
`define CSCC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cscc_pkg.sv -----
// shared types, constants and crc function for the chunk stream crc checker
package cscc_pkg;

    localparam logic [31:0] CRC_POLY    = 32'h1edc6f41;
    localparam logic [31:0] TYPE_HEADER = 32'h50424954;
    localparam logic [31:0] TYPE_TEXT   = 32'h54455854;
    localparam logic [31:0] TYPE_TRACK  = 32'h5452414b;
    localparam logic [31:0] TYPE_DATA   = 32'h44415441;
    localparam logic [31:0] TYPE_END    = 32'h454e4420;

    localparam logic [31:0] HEADER_MIN_LEN = 32'd8;
    localparam logic [31:0] TRACK_MIN_LEN  = 32'd20;

    typedef enum logic [2:0] {
        K_HEADER  = 3'd0,
        K_TEXT    = 3'd1,
        K_TRACK   = 3'd2,
        K_DATA    = 3'd3,
        K_END     = 3'd4,
        K_UNKNOWN = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CRC       = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_VERSION   = 3'd3,
        ST_HDR_SHORT = 3'd4,
        ST_TRK_SHORT = 3'd5,
        ST_NO_TRACK  = 3'd6
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] length;
        status_t     status;
        logic        done;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {b, 24'h0};
        for (int i = 0; i < 8; i++) begin
            if (r[31]) begin
                r = {r[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[30:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic kind_t kind_of(input logic [31:0] t, input logic first);
        kind_t k;
        if (first) begin
            k = K_HEADER;
        end else begin
            case (t)
                TYPE_TEXT:  k = K_TEXT;
                TYPE_TRACK: k = K_TRACK;
                TYPE_DATA:  k = K_DATA;
                TYPE_END:   k = K_END;
                default:    k = K_UNKNOWN;
            endcase
        end
        return k;
    endfunction

endpackage

// ----- rtl/cscc_in_stage.sv -----
// input register for the byte stream
module cscc_in_stage
    import cscc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_new_file,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_data,
    output logic       in_new_file
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       new_file_reg;

    assign s_ready     = !valid_reg || advance;
    assign in_valid    = valid_reg;
    assign in_data     = data_reg;
    assign in_new_file = new_file_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg     <= s_data_byte;
            new_file_reg <= s_new_file;
        end
    end

endmodule

// ----- rtl/cscc_parser.sv -----
// chunk parser state and one-byte update with crc
module cscc_parser
    import cscc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] in_data,
    input  logic       in_new_file,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC,
        PH_STOPPED
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [31:0] count_reg, count_next, count_cur, count_inc;
    logic [31:0] type_reg, type_next, type_cur;
    logic [31:0] len_reg, len_next, len_cur;
    logic [31:0] crc_reg, crc_next, crc_cur, crc_upd;
    logic [31:0] rcrc_reg, rcrc_next, rcrc_cur;
    logic        track_reg, track_next, track_cur;
    logic        first_reg, first_next, first_cur;
    logic        vnz_reg, vnz_next, vnz_cur;
    kind_t       kind;

    // restart substitutes the reset state
    always_comb begin
        if (in_new_file) begin
            phase_cur = PH_HEADER;
            count_cur = '0;
            type_cur  = '0;
            len_cur   = '0;
            crc_cur   = '0;
            rcrc_cur  = '0;
            track_cur = 1'b0;
            first_cur = 1'b1;
            vnz_cur   = 1'b0;
        end else begin
            phase_cur = phase_reg;
            count_cur = count_reg;
            type_cur  = type_reg;
            len_cur   = len_reg;
            crc_cur   = crc_reg;
            rcrc_cur  = rcrc_reg;
            track_cur = track_reg;
            first_cur = first_reg;
            vnz_cur   = vnz_reg;
        end
    end

    assign crc_upd   = crc_byte(crc_cur, in_data);
    assign count_inc = count_cur + 32'd1;

    always_comb begin
        phase_next = phase_cur;
        count_next = count_cur;
        type_next  = type_cur;
        len_next   = len_cur;
        crc_next   = crc_cur;
        rcrc_next  = rcrc_cur;
        track_next = track_cur;
        first_next = first_cur;
        vnz_next   = vnz_cur;
        res_valid  = 1'b0;
        res        = '{kind: K_HEADER, length: '0, status: ST_OK, done: 1'b0};
        kind       = K_HEADER;
        unique case (phase_cur)
            PH_HEADER: begin
                crc_next   = crc_upd;
                count_next = count_inc;
                if (count_cur < 32'd4) begin
                    type_next = {type_cur[23:0], in_data};
                end else begin
                    len_next = {len_cur[23:0], in_data};
                end
                if (count_inc == 32'd4 && first_cur && type_next != TYPE_HEADER) begin
                    phase_next = PH_STOPPED;
                    res_valid  = 1'b1;
                    res        = '{kind: kind_of(type_next, 1'b0), length: '0,
                                   status: ST_MAGIC, done: 1'b1};
                end else if (count_inc == 32'd8) begin
                    count_next = '0;
                    kind       = kind_of(type_next, first_cur);
                    if (first_cur && len_next < HEADER_MIN_LEN) begin
                        phase_next = PH_STOPPED;
                        res_valid  = 1'b1;
                        res        = '{kind: kind, length: len_next,
                                       status: ST_HDR_SHORT, done: 1'b1};
                    end else if (kind == K_TRACK && len_next < TRACK_MIN_LEN) begin
                        phase_next = PH_STOPPED;
                        res_valid  = 1'b1;
                        res        = '{kind: kind, length: len_next,
                                       status: ST_TRK_SHORT, done: 1'b1};
                    end else if (kind == K_DATA && !track_cur) begin
                        phase_next = PH_STOPPED;
                        res_valid  = 1'b1;
                        res        = '{kind: kind, length: len_next,
                                       status: ST_NO_TRACK, done: 1'b1};
                    end else begin
                        rcrc_next  = '0;
                        phase_next = (len_next != '0) ? PH_PAYLOAD : PH_CRC;
                    end
                end
            end
            PH_PAYLOAD: begin
                crc_next   = crc_upd;
                count_next = count_inc;
                if (first_cur && count_cur < 32'd4 && in_data != 8'h00) begin
                    vnz_next = 1'b1;
                end
                if (first_cur && count_inc == 32'd8 && vnz_next) begin
                    phase_next = PH_STOPPED;
                    res_valid  = 1'b1;
                    res        = '{kind: K_HEADER, length: len_cur,
                                   status: ST_VERSION, done: 1'b1};
                end else if (count_inc == len_cur) begin
                    count_next = '0;
                    phase_next = PH_CRC;
                end
            end
            PH_CRC: begin
                rcrc_next  = {rcrc_cur[23:0], in_data};
                count_next = count_inc;
                if (count_inc == 32'd4) begin
                    kind = kind_of(type_cur, first_cur);
                    if (rcrc_next != crc_cur) begin
                        phase_next = PH_STOPPED;
                        res_valid  = 1'b1;
                        res        = '{kind: kind, length: len_cur,
                                       status: ST_CRC, done: 1'b1};
                    end else begin
                        if (kind == K_TRACK) begin
                            track_next = 1'b1;
                        end
                        first_next = 1'b0;
                        count_next = '0;
                        crc_next   = '0;
                        type_next  = '0;
                        phase_next = (kind == K_END) ? PH_STOPPED : PH_HEADER;
                        res_valid  = 1'b1;
                        res        = '{kind: kind, length: len_cur,
                                       status: ST_OK, done: (kind == K_END)};
                    end
                end
            end
            PH_STOPPED: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            crc_reg   <= '0;
            rcrc_reg  <= '0;
            track_reg <= 1'b0;
            first_reg <= 1'b1;
            vnz_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            rcrc_reg  <= rcrc_next;
            track_reg <= track_next;
            first_reg <= first_next;
            vnz_reg   <= vnz_next;
        end
    end

endmodule

// ----- rtl/cscc_out_stage.sv -----
// result register for chunk reports
module cscc_out_stage
    import cscc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     res,
    output logic        can_take,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_chunk_kind,
    output logic [31:0] m_chunk_length,
    output logic [2:0]  m_status,
    output logic        m_file_done
);

    logic    valid_reg;
    result_t res_reg;

    assign can_take       = !valid_reg || m_ready;
    assign m_valid        = valid_reg;
    assign m_chunk_kind   = res_reg.kind;
    assign m_chunk_length = res_reg.length;
    assign m_status       = res_reg.status;
    assign m_file_done    = res_reg.done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// ----- rtl/chunk_stream_crc_checker.sv -----
// top level of the chunk stream parser with castagnoli crc check
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  input   | s_valid s_ready s_data_byte s_new_file             | in
//  result  | m_valid m_ready m_chunk_kind m_chunk_length        | out
//          | m_status m_file_done                               |
//
// one byte per cycle sustained while the result side is not stalled; a byte's report
// passes through the input register and then the result register behind the parser
// reset is synchronous and active low; it empties both registers and puts the
// parser at the start of a file
// a stalled result holds the parser; one more byte is still taken into the
// input register
module chunk_stream_crc_checker
    import cscc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_new_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_chunk_kind,
    output logic [31:0] m_chunk_length,
    output logic [2:0]  m_status,
    output logic        m_file_done
);

    logic       in_valid;
    logic [7:0] in_data;
    logic       in_new_file;
    logic       can_take;
    logic       advance;
    logic       res_valid;
    result_t    res;

    assign advance = in_valid && can_take;

    cscc_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_new_file  (s_new_file),
        .advance     (advance),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .in_new_file (in_new_file)
    );

    cscc_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_data     (in_data),
        .in_new_file (in_new_file),
        .res_valid   (res_valid),
        .res         (res)
    );

    cscc_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (advance && res_valid),
        .res            (res),
        .can_take       (can_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chunk_kind   (m_chunk_kind),
        .m_chunk_length (m_chunk_length),
        .m_status       (m_status),
        .m_file_done    (m_file_done)
    );

endmodule

// ----- rtl/cscc_checker.sv -----
// port-level assertions for the chunk stream crc checker and their bind
`include "chunk_stream_crc_checker_defines.svh"

module cscc_checker
    import cscc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_chunk_kind,
    input logic [31:0] m_chunk_length,
    input logic [2:0]  m_status,
    input logic        m_file_done
);

    `CSCC_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_chunk_kind) && $stable(m_chunk_length) && $stable(m_status) && $stable(m_file_done), "stalled result changed")
    `CSCC_ASSERT_NOW(a_error_done, aclk, aresetn, m_valid && m_status != ST_OK, m_file_done, "error report without file done")
    `CSCC_ASSERT_NOW(a_ok_done_end, aclk, aresetn, m_valid && m_status == ST_OK, m_file_done == (m_chunk_kind == K_END), "file done on good chunk other than end")
    `CSCC_ASSERT_NOW(a_magic_len, aclk, aresetn, m_valid && m_status == ST_MAGIC, m_chunk_length == 32'd0, "bad magic report with nonzero length")

endmodule

bind chunk_stream_crc_checker cscc_checker u_cscc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_chunk_kind   (m_chunk_kind),
    .m_chunk_length (m_chunk_length),
    .m_status       (m_status),
    .m_file_done    (m_file_done)
);

// ----- tb/tb_chunk_stream_crc_checker.sv -----
// testbench for chunk_stream_crc_checker: byte-level scoreboard against directed and randomized image files
import cscc_pkg::*;

typedef enum logic [1:0] {
    PP_HEADER,
    PP_PAYLOAD,
    PP_CRC,
    PP_STOPPED
} parse_phase_t;

typedef struct {
    kind_t       kind;
    logic [31:0] length;
    status_t     status;
    logic        done;
} chunk_report_t;

function automatic logic [31:0] crc32_update(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int i = 7; i >= 0; i--) begin
        if (r[31] ^ b[i]) begin
            r = {r[30:0], 1'b0} ^ CRC_POLY;
        end else begin
            r = {r[30:0], 1'b0};
        end
    end
    return r;
endfunction

class chunk_scoreboard;
    parse_phase_t  parse_phase;
    logic [31:0]   byte_idx;
    logic [31:0]   word_type;
    logic [31:0]   word_len;
    logic [31:0]   crc_acc;
    logic [31:0]   crc_rx;
    bit            track_ok;
    bit            in_first;
    bit            version_bad;
    chunk_report_t reports[$];
    int            mismatches;

    function new();
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        parse_phase = PP_HEADER;
        byte_idx    = 32'd0;
        word_type   = 32'd0;
        word_len    = 32'd0;
        crc_acc     = 32'd0;
        crc_rx      = 32'd0;
        track_ok    = 1'b0;
        in_first    = 1'b1;
        version_bad = 1'b0;
    endfunction

    function kind_t decode_kind(logic [31:0] t, bit hdr);
        if (hdr) begin
            return K_HEADER;
        end
        case (t)
            TYPE_TEXT:  return K_TEXT;
            TYPE_TRACK: return K_TRACK;
            TYPE_DATA:  return K_DATA;
            TYPE_END:   return K_END;
            default:    return K_UNKNOWN;
        endcase
    endfunction

    function void queue_report(kind_t k, logic [31:0] len, status_t st, logic d);
        chunk_report_t e;
        e.kind   = k;
        e.length = len;
        e.status = st;
        e.done   = d;
        reports.push_back(e);
    endfunction

    function void stop_with(kind_t k, logic [31:0] len, status_t st);
        parse_phase = PP_STOPPED;
        queue_report(k, len, st, 1'b1);
    endfunction

    function void note_input(logic [7:0] b, logic nf);
        kind_t k;
        if (nf) begin
            restart();
        end
        case (parse_phase)
            PP_HEADER: begin
                crc_acc = crc32_update(crc_acc, b);
                if (byte_idx < 4) begin
                    word_type = {word_type[23:0], b};
                end else begin
                    word_len = {word_len[23:0], b};
                end
                byte_idx++;
                if (byte_idx == 4 && in_first && word_type != TYPE_HEADER) begin
                    stop_with(decode_kind(word_type, 1'b0), 32'd0, ST_MAGIC);
                end else if (byte_idx == 8) begin
                    byte_idx = 32'd0;
                    k = decode_kind(word_type, in_first);
                    if (in_first && word_len < HEADER_MIN_LEN) begin
                        stop_with(k, word_len, ST_HDR_SHORT);
                    end else if (k == K_TRACK && word_len < TRACK_MIN_LEN) begin
                        stop_with(k, word_len, ST_TRK_SHORT);
                    end else if (k == K_DATA && !track_ok) begin
                        stop_with(k, word_len, ST_NO_TRACK);
                    end else begin
                        crc_rx      = 32'd0;
                        parse_phase = (word_len != 0) ? PP_PAYLOAD : PP_CRC;
                    end
                end
            end
            PP_PAYLOAD: begin
                crc_acc = crc32_update(crc_acc, b);
                if (in_first && byte_idx < 4 && b != 8'h00) begin
                    version_bad = 1'b1;
                end
                byte_idx++;
                if (in_first && byte_idx == 8 && version_bad) begin
                    stop_with(K_HEADER, word_len, ST_VERSION);
                end else if (byte_idx == word_len) begin
                    byte_idx    = 32'd0;
                    parse_phase = PP_CRC;
                end
            end
            PP_CRC: begin
                crc_rx = {crc_rx[23:0], b};
                byte_idx++;
                if (byte_idx == 4) begin
                    k = decode_kind(word_type, in_first);
                    if (crc_rx != crc_acc) begin
                        stop_with(k, word_len, ST_CRC);
                    end else begin
                        if (k == K_TRACK) begin
                            track_ok = 1'b1;
                        end
                        in_first  = 1'b0;
                        byte_idx  = 32'd0;
                        crc_acc   = 32'd0;
                        word_type = 32'd0;
                        queue_report(k, word_len, ST_OK, k == K_END);
                        parse_phase = (k == K_END) ? PP_STOPPED : PP_HEADER;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function void check_result(logic [2:0] k, logic [31:0] len, logic [2:0] st, logic d);
        chunk_report_t e;
        if (reports.size() == 0) begin
            flag($sformatf("unexpected result: kind %0d length %0h status %0d done %0b",
                           k, len, st, d));
            return;
        end
        e = reports.pop_front();
        if (e.kind !== k || e.length !== len || e.status !== st || e.done !== d) begin
            flag($sformatf({"mismatch: kind %0d/%0d length %0h/%0h status %0d/%0d ",
                            "done %0b/%0b (expected/actual)"},
                           e.kind, k, e.length, len, e.status, st, e.done, d));
        end
    endfunction

    function int pending();
        return reports.size();
    endfunction
endclass

module tb_chunk_stream_crc_checker;
    localparam int ITEMS       = 1800;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 300;

    localparam int HEAD_NONE         = 0;
    localparam int HEAD_ZERO_VERSION = 1;
    localparam int HEAD_BAD_VERSION  = 2;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte    = 8'h00;
    logic        s_new_file     = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [2:0]  m_chunk_kind;
    logic [31:0] m_chunk_length;
    logic [2:0]  m_status;
    logic        m_file_done;

    chunk_scoreboard sb;
    logic [7:0]      file_bytes[$];
    logic [31:0]     build_crc;
    int              idle_cycles = 0;
    int              sent        = 0;
    bit              hold_req    = 1'b0;

    chunk_stream_crc_checker i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_new_file     (s_new_file),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chunk_kind   (m_chunk_kind),
        .m_chunk_length (m_chunk_length),
        .m_status       (m_status),
        .m_file_done    (m_file_done)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_input(s_data_byte, s_new_file);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_chunk_kind, m_chunk_length, m_status, m_file_done);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // result side: random back-pressure, long stalls, and one forced hold-off
    initial begin
        int stall_left;
        int mode_left;
        int ready_pct;
        stall_left = 0;
        mode_left  = 0;
        ready_pct  = 100;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                if (mode_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       ready_pct = 100;
                        1:       ready_pct = 90;
                        2:       ready_pct = 60;
                        default: ready_pct = 30;
                    endcase
                    mode_left = 150;
                end
                mode_left--;
                if ($urandom_range(0, 199) == 0) begin
                    stall_left = $urandom_range(20, 60);
                end
                m_ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic bit corrupt();
        return $urandom_range(0, 99) < 3;
    endfunction

    function automatic void add_byte(logic [7:0] b);
        file_bytes.push_back(b);
        build_crc = crc32_update(build_crc, b);
    endfunction

    function automatic void add_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--) begin
            add_byte(w[8*i +: 8]);
        end
    endfunction

    function automatic void add_chunk(logic [31:0] tw, logic [31:0] ln, int head_mode, bit flip);
        logic [31:0] c;
        int          bad_at;
        build_crc = 32'd0;
        bad_at    = $urandom_range(0, 3);
        add_word(tw);
        add_word(ln);
        for (int i = 0; i < ln; i++) begin
            if (head_mode != HEAD_NONE && i < 4) begin
                add_byte((head_mode == HEAD_BAD_VERSION && i == bad_at) ?
                         8'($urandom_range(1, 255)) : 8'h00);
            end else begin
                add_byte(8'($urandom));
            end
        end
        c = flip ? (build_crc ^ (32'h1 << $urandom_range(0, 31))) : build_crc;
        for (int i = 3; i >= 0; i--) begin
            file_bytes.push_back(c[8*i +: 8]);
        end
    endfunction

    task automatic build_file();
        int          r;
        int          n_mid;
        logic [31:0] tw;
        bit          cut_short;
        cut_short = 1'b0;
        file_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 4) begin
            case ($urandom_range(0, 3))
                0:       tw = TYPE_HEADER ^ (32'h1 << $urandom_range(0, 31));
                1:       tw = TYPE_TRACK;
                2:       tw = TYPE_END;
                default: tw = $urandom;
            endcase
            add_chunk(tw, 32'd8, HEAD_ZERO_VERSION, 1'b0);
        end else if (r < 8) begin
            add_chunk(TYPE_HEADER, $urandom_range(0, 7), HEAD_ZERO_VERSION, 1'b0);
        end else if (r < 12) begin
            add_chunk(TYPE_HEADER, $urandom_range(8, 16), HEAD_BAD_VERSION, 1'b0);
        end else begin
            add_chunk(TYPE_HEADER, ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : 8,
                      HEAD_ZERO_VERSION, corrupt());
        end
        n_mid = $urandom_range(0, 6);
        for (int i = 0; i < n_mid && !cut_short; i++) begin
            r = (i == 0 && $urandom_range(0, 9) < 7) ? 30 : $urandom_range(0, 99);
            if (r < 20) begin
                add_chunk(TYPE_TEXT, $urandom_range(0, 30), HEAD_NONE, corrupt());
            end else if (r < 45) begin
                add_chunk(TYPE_TRACK, ($urandom_range(0, 15) == 0) ? $urandom_range(0, 19) :
                          $urandom_range(20, 40), HEAD_NONE, corrupt());
            end else if (r < 75) begin
                add_chunk(TYPE_DATA, ($urandom_range(0, 30) == 0) ? $urandom_range(256, 600) :
                          $urandom_range(0, 40), HEAD_NONE, corrupt());
            end else if (r < 88) begin
                add_chunk($urandom, $urandom_range(0, 24), HEAD_NONE, corrupt());
            end else if (r < 95) begin
                add_chunk(TYPE_HEADER, $urandom_range(0, 12), HEAD_NONE, corrupt());
            end else begin
                // random declared size, at most ten payload bytes follow before the next file
                add_word($urandom_range(0, 1) ? TYPE_DATA : $urandom);
                add_word($urandom);
                repeat ($urandom_range(0, 10)) add_byte(8'($urandom));
                cut_short = 1'b1;
            end
        end
        if (!cut_short && $urandom_range(0, 9) != 0) begin
            add_chunk(TYPE_END, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0,
                      HEAD_NONE, corrupt());
        end
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, file_bytes.size() - 1)) void'(file_bytes.pop_back());
        end
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic nf, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_new_file  <= nf;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_file(input bit no_gaps);
        foreach (file_bytes[i]) begin
            send_byte(file_bytes[i], i == 0, no_gaps ? 0 : pick_gap());
        end
        sent += file_bytes.size();
    endtask

    initial begin
        int nfile;
        sb = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // bad magic from all-ones bytes, then bytes that a stopped parser drops
        file_bytes = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00};
        send_file(1'b0);
        // file header with a nonzero version word
        file_bytes.delete();
        add_word(TYPE_HEADER);
        add_word(32'd8);
        add_word(32'h0000_0080);
        add_word(32'd0);
        send_file(1'b0);

        for (nfile = 0; sent < ITEMS; nfile++) begin
            build_file();
            if (nfile == 3) begin
                hold_req = 1'b1;
            end
            if (nfile == 6) begin
                s_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge aclk);
                @(negedge aclk);
            end
            send_file($urandom_range(0, 3) == 0);
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
